// ===== sv/armed_command_frame_interlock_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ARMED_COMMAND_FRAME_INTERLOCK_MACROS_SVH
`define ARMED_COMMAND_FRAME_INTERLOCK_MACROS_SVH

// property checked on every edge outside reset
`define ACFI_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("acfi check failed");

// property checked on every edge, reset included
`define ACFI_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("acfi check failed");

`endif

// ===== sv/acfi_pkg.sv =====
// types and constants of the armed command frame interlock
package acfi_pkg;

    localparam int WORD_W      = 32;
    localparam int ANGLE_W     = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int STATUS_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MAX = 8'd1;

    localparam logic [ANGLE_W-1:0] SERVO_MIN_RESET = 8'd5;
    localparam logic [ANGLE_W-1:0] SERVO_MAX_RESET = 8'd85;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

    // command word meaning "on"
    localparam logic [WORD_W-1:0] CMD_ON = 32'd1;

    typedef struct packed {
        logic signed [WORD_W-1:0] data_cmd;
        logic signed [WORD_W-1:0] arm_cmd;
        logic signed [WORD_W-1:0] solenoid_cmd;
        logic signed [WORD_W-1:0] ignition_cmd;
        logic signed [WORD_W-1:0] siren_cmd;
        logic signed [WORD_W-1:0] spare_word;
        logic signed [WORD_W-1:0] servo_angle_cmd;
        logic signed [WORD_W-1:0] frame_checksum;
    } frame_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                armed;
        logic                data_enabled;
        logic                solenoid_on;
        logic                ignition_on;
        logic                siren_on;
        logic                servo_move;
        logic [ANGLE_W-1:0]  servo_angle;
        logic                servo_out_of_range;
    } result_t;

    // captured frame with the checksum partly summed
    typedef struct packed {
        frame_t              frame;
        logic [WORD_W-1:0]   sum01;
        logic [WORD_W-1:0]   sum23;
        logic [WORD_W-1:0]   sum45;
    } stage_t;

endpackage

// ===== sv/acfi_in_stage.sv =====
// input register holding one request and its pairwise checksum sums
module acfi_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              advance,
    input  acfi_pkg::frame_t  frame,
    output logic              stage_valid,
    output acfi_pkg::stage_t  stage
);

    logic             valid_reg;
    logic             valid_next;
    acfi_pkg::stage_t stage_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg.frame <= frame;
            stage_reg.sum01 <= frame.data_cmd + frame.arm_cmd;
            stage_reg.sum23 <= frame.solenoid_cmd + frame.ignition_cmd;
            stage_reg.sum45 <= frame.siren_cmd + frame.spare_word;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== sv/acfi_ctrl.sv =====
// channel state and the per-frame interlock decision
module acfi_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            commit,
    input  acfi_pkg::stage_t                stage,
    input  logic [acfi_pkg::ANGLE_W-1:0]    servo_min,
    input  logic [acfi_pkg::ANGLE_W-1:0]    servo_max,
    output acfi_pkg::result_t               result
);

    logic [acfi_pkg::WORD_W-1:0] last_data_reg,     last_data_next;
    logic [acfi_pkg::WORD_W-1:0] last_arm_reg,      last_arm_next;
    logic [acfi_pkg::WORD_W-1:0] last_solenoid_reg, last_solenoid_next;
    logic [acfi_pkg::WORD_W-1:0] last_ignition_reg, last_ignition_next;
    logic [acfi_pkg::WORD_W-1:0] last_siren_reg,    last_siren_next;
    logic [acfi_pkg::WORD_W-1:0] last_angle_reg,    last_angle_next;
    logic                        armed_reg,         armed_next;
    logic                        data_flag_reg,     data_flag_next;
    logic                        solenoid_reg,      solenoid_next;
    logic                        ignition_reg,      ignition_next;
    logic                        siren_reg,         siren_next;

    logic [acfi_pkg::WORD_W-1:0] sum;
    logic                        sum_ok;
    logic                        refused;
    logic                        angle_ok;
    logic                        move;
    logic                        out_of_range;
    logic [acfi_pkg::STATUS_W-1:0] status;

    always_comb
    begin
        sum      = stage.sum01 + stage.sum23 + stage.sum45
                 + stage.frame.servo_angle_cmd;
        sum_ok   = (sum == stage.frame.frame_checksum);
        angle_ok = (stage.frame.servo_angle_cmd >=
                        $signed({{(acfi_pkg::WORD_W-acfi_pkg::ANGLE_W){1'b0}}, servo_min}))
                && (stage.frame.servo_angle_cmd <=
                        $signed({{(acfi_pkg::WORD_W-acfi_pkg::ANGLE_W){1'b0}}, servo_max}));

        last_data_next     = last_data_reg;
        last_arm_next      = last_arm_reg;
        last_solenoid_next = last_solenoid_reg;
        last_ignition_next = last_ignition_reg;
        last_siren_next    = last_siren_reg;
        last_angle_next    = last_angle_reg;
        armed_next         = armed_reg;
        data_flag_next     = data_flag_reg;
        solenoid_next      = solenoid_reg;
        ignition_next      = ignition_reg;
        siren_next         = siren_reg;
        refused            = 1'b0;
        move               = 1'b0;
        out_of_range       = 1'b0;

        if (sum_ok)
        begin
            if (stage.frame.data_cmd != last_data_reg)
            begin
                data_flag_next = (stage.frame.data_cmd == acfi_pkg::CMD_ON);
                last_data_next = stage.frame.data_cmd;
            end

            if (stage.frame.arm_cmd != last_arm_reg)
            begin
                last_arm_next = stage.frame.arm_cmd;
                if (stage.frame.arm_cmd == acfi_pkg::CMD_ON)
                begin
                    armed_next = 1'b1;
                end
                else
                begin
                    armed_next    = 1'b0;
                    solenoid_next = 1'b0;
                    ignition_next = 1'b0;
                    siren_next    = 1'b0;
                end
            end

            if (stage.frame.solenoid_cmd != last_solenoid_reg)
            begin
                if (stage.frame.solenoid_cmd == acfi_pkg::CMD_ON && !armed_next)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    solenoid_next      = (stage.frame.solenoid_cmd == acfi_pkg::CMD_ON);
                    last_solenoid_next = stage.frame.solenoid_cmd;
                end
            end

            // the frame stops at the first refused on-request
            if (!refused && stage.frame.ignition_cmd != last_ignition_reg)
            begin
                if (stage.frame.ignition_cmd == acfi_pkg::CMD_ON && !armed_next)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    ignition_next      = (stage.frame.ignition_cmd == acfi_pkg::CMD_ON);
                    last_ignition_next = stage.frame.ignition_cmd;
                end
            end

            if (!refused)
            begin
                if (stage.frame.siren_cmd != last_siren_reg)
                begin
                    siren_next      = (stage.frame.siren_cmd == acfi_pkg::CMD_ON);
                    last_siren_next = stage.frame.siren_cmd;
                end
                if (stage.frame.servo_angle_cmd != last_angle_reg)
                begin
                    if (angle_ok)
                    begin
                        last_angle_next = stage.frame.servo_angle_cmd;
                        move            = 1'b1;
                    end
                    else
                    begin
                        out_of_range = 1'b1;
                    end
                end
            end
        end

        if (!sum_ok)
        begin
            status = acfi_pkg::STATUS_BAD_SUM;
        end
        else if (refused)
        begin
            status = acfi_pkg::STATUS_REFUSED;
        end
        else
        begin
            status = acfi_pkg::STATUS_OK;
        end

        result.status             = status;
        result.armed              = armed_next;
        result.data_enabled       = data_flag_next;
        result.solenoid_on        = solenoid_next;
        result.ignition_on        = ignition_next;
        result.siren_on           = siren_next;
        result.servo_move         = move;
        result.servo_angle        = last_angle_next[acfi_pkg::ANGLE_W-1:0];
        result.servo_out_of_range = out_of_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_data_reg     <= '0;
            last_arm_reg      <= '0;
            last_solenoid_reg <= '0;
            last_ignition_reg <= '0;
            last_siren_reg    <= '0;
            last_angle_reg    <= '0;
            armed_reg         <= 1'b0;
            data_flag_reg     <= 1'b0;
            solenoid_reg      <= 1'b0;
            ignition_reg      <= 1'b0;
            siren_reg         <= 1'b0;
        end
        else if (commit)
        begin
            last_data_reg     <= last_data_next;
            last_arm_reg      <= last_arm_next;
            last_solenoid_reg <= last_solenoid_next;
            last_ignition_reg <= last_ignition_next;
            last_siren_reg    <= last_siren_next;
            last_angle_reg    <= last_angle_next;
            armed_reg         <= armed_next;
            data_flag_reg     <= data_flag_next;
            solenoid_reg      <= solenoid_next;
            ignition_reg      <= ignition_next;
            siren_reg         <= siren_next;
        end
    end

endmodule

// ===== sv/armed_command_frame_interlock.sv =====
// Armed command frame interlock: one result per command frame, one frame per clock
// sustained while the downstream side takes results. A frame is registered on input,
// then checked and applied to the channel state as it moves into the output register,
// which holds its result. The result register and the input register both advance
// while the downstream side takes results, letting a new request in on every cycle;
// a stalled output holds one result and one frame in flight.
// Servo limit registers are written on the cfg channel, which is always ready.
module armed_command_frame_interlock (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  acfi_pkg::frame_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output acfi_pkg::result_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acfi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acfi_pkg::ANGLE_W-1:0]    cfg_data
);

    logic                         stage_valid;
    acfi_pkg::stage_t             stage;
    acfi_pkg::result_t            result;
    logic                         advance;
    logic                         take;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    acfi_pkg::result_t            out_data_reg;
    logic [acfi_pkg::ANGLE_W-1:0] servo_min_reg;
    logic [acfi_pkg::ANGLE_W-1:0] servo_max_reg;

    // the frame in the input register moves on when the result slot is free or its result is being taken
    assign advance  = stage_valid && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid || advance;
    assign take     = in_valid && in_ready;

    acfi_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .advance     (advance),
        .frame       (in_data),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    acfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (advance),
        .stage     (stage),
        .servo_min (servo_min_reg),
        .servo_max (servo_max_reg),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_min_reg <= acfi_pkg::SERVO_MIN_RESET;
            servo_max_reg <= acfi_pkg::SERVO_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                acfi_pkg::REG_SERVO_MIN: servo_min_reg <= cfg_data;
                acfi_pkg::REG_SERVO_MAX: servo_max_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/acfi_checker.sv =====
// port-level checks on the interlock and their binding
`include "armed_command_frame_interlock_macros.svh"

module acfi_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_ready,
    input  acfi_pkg::result_t out_data
);

    // a held result stays put
    `ACFI_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

    // solenoid and ignition are never on while disarmed
    `ACFI_ASSERT_RST(a_disarmed_safe, clk, rst_n, out_valid && !out_data.armed |-> !out_data.solenoid_on && !out_data.ignition_on)

    // a rejected or refused frame never touches the servo
    `ACFI_ASSERT_RST(a_servo_quiet, clk, rst_n, out_valid && out_data.status != acfi_pkg::STATUS_OK |-> !out_data.servo_move && !out_data.servo_out_of_range)

    // a servo request is either taken or flagged, not both
    `ACFI_ASSERT_RST(a_servo_excl, clk, rst_n, out_valid |-> !(out_data.servo_move && out_data.servo_out_of_range))

    // no result shows during reset
    `ACFI_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid)

endmodule

bind armed_command_frame_interlock acfi_checker u_acfi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== dv/armed_command_frame_interlock_checker.sv =====
// result checker for the armed command frame interlock: predicts every result and compares it
`timescale 1ns / 100ps
module armed_command_frame_interlock_checker
    import acfi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  frame_t               in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  result_t              out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ANGLE_W-1:0]   cfg_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   frames_seen,
    output int                   bad_sum_seen,
    output int                   refused_seen,
    output int                   moves_seen,
    output int                   out_of_range_seen
);

    logic [ANGLE_W-1:0] lim_lo;
    logic [ANGLE_W-1:0] lim_hi;
    logic [WORD_W-1:0]  prev_data;
    logic [WORD_W-1:0]  prev_arm;
    logic [WORD_W-1:0]  prev_sol;
    logic [WORD_W-1:0]  prev_ign;
    logic [WORD_W-1:0]  prev_siren;
    logic [WORD_W-1:0]  prev_angle;
    logic               armed_q;
    logic               data_q;
    logic               sol_q;
    logic               ign_q;
    logic               siren_q;
    int                 results_taken;
    result_t            pending_results[$];

    function automatic result_t with_levels(result_t r);
        r.armed        = armed_q;
        r.data_enabled = data_q;
        r.solenoid_on  = sol_q;
        r.ignition_on  = ign_q;
        r.siren_on     = siren_q;
        r.servo_angle  = prev_angle[ANGLE_W-1:0];
        return r;
    endfunction

    // applies one frame to the channel state and returns the result it should produce
    function automatic result_t predict_interlock(frame_t f);
        logic [WORD_W-1:0] sum;
        result_t           r;
        int                angle;
        r   = '0;
        sum = f.data_cmd + f.arm_cmd + f.solenoid_cmd + f.ignition_cmd + f.siren_cmd
            + f.spare_word + f.servo_angle_cmd;
        if (sum != WORD_W'(f.frame_checksum)) begin
            r.status = STATUS_BAD_SUM;
            return with_levels(r);
        end
        if (f.data_cmd != prev_data) begin
            data_q    = (f.data_cmd == CMD_ON);
            prev_data = f.data_cmd;
        end
        if (f.arm_cmd != prev_arm) begin
            if (f.arm_cmd == CMD_ON) begin
                armed_q = 1'b1;
            end else begin
                armed_q = 1'b0;
                sol_q   = 1'b0;
                ign_q   = 1'b0;
                siren_q = 1'b0;
            end
            prev_arm = f.arm_cmd;
        end
        // refusal stops the frame: the refused word and later channels stay as they were
        if (f.solenoid_cmd != prev_sol) begin
            if (f.solenoid_cmd == CMD_ON) begin
                if (!armed_q) begin
                    r.status = STATUS_REFUSED;
                    return with_levels(r);
                end
                sol_q = 1'b1;
            end else begin
                sol_q = 1'b0;
            end
            prev_sol = f.solenoid_cmd;
        end
        if (f.ignition_cmd != prev_ign) begin
            if (f.ignition_cmd == CMD_ON) begin
                if (!armed_q) begin
                    r.status = STATUS_REFUSED;
                    return with_levels(r);
                end
                ign_q = 1'b1;
            end else begin
                ign_q = 1'b0;
            end
            prev_ign = f.ignition_cmd;
        end
        if (f.siren_cmd != prev_siren) begin
            siren_q    = (f.siren_cmd == CMD_ON);
            prev_siren = f.siren_cmd;
        end
        if (f.servo_angle_cmd != prev_angle) begin
            angle = f.servo_angle_cmd;
            if (angle >= int'(lim_lo) && angle <= int'(lim_hi)) begin
                prev_angle   = f.servo_angle_cmd;
                r.servo_move = 1'b1;
            end else begin
                r.servo_out_of_range = 1'b1;
            end
        end
        r.status = STATUS_OK;
        return with_levels(r);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: result %0d %s is %0d, expected %0d",
                 $time, results_taken, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            lim_lo            = SERVO_MIN_RESET;
            lim_hi            = SERVO_MAX_RESET;
            prev_data         = '0;
            prev_arm          = '0;
            prev_sol          = '0;
            prev_ign          = '0;
            prev_siren        = '0;
            prev_angle        = '0;
            armed_q           = 1'b0;
            data_q            = 1'b0;
            sol_q             = 1'b0;
            ign_q             = 1'b0;
            siren_q           = 1'b0;
            results_taken     = 0;
            mismatches        = 0;
            frames_seen       = 0;
            bad_sum_seen      = 0;
            refused_seen      = 0;
            moves_seen        = 0;
            out_of_range_seen = 0;
            pending_results.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                // other indexes are ignored by the block
                if (cfg_index == REG_SERVO_MIN) begin
                    lim_lo = cfg_data;
                end else if (cfg_index == REG_SERVO_MAX) begin
                    lim_hi = cfg_data;
                end
            end
            if (in_valid && in_ready) begin
                want = predict_interlock(in_data);
                pending_results.push_back(want);
                frames_seen++;
                if (want.status == STATUS_BAD_SUM) bad_sum_seen++;
                if (want.status == STATUS_REFUSED) refused_seen++;
                if (want.servo_move) moves_seen++;
                if (want.servo_out_of_range) out_of_range_seen++;
            end
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    // a result with no frame behind it
                    report_mismatch("pending frame count", 0, 1);
                end else begin
                    want = pending_results.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.armed !== want.armed)
                        report_mismatch("armed", out_data.armed, want.armed);
                    if (out_data.data_enabled !== want.data_enabled)
                        report_mismatch("data_enabled", out_data.data_enabled,
                                        want.data_enabled);
                    if (out_data.solenoid_on !== want.solenoid_on)
                        report_mismatch("solenoid_on", out_data.solenoid_on, want.solenoid_on);
                    if (out_data.ignition_on !== want.ignition_on)
                        report_mismatch("ignition_on", out_data.ignition_on, want.ignition_on);
                    if (out_data.siren_on !== want.siren_on)
                        report_mismatch("siren_on", out_data.siren_on, want.siren_on);
                    if (out_data.servo_move !== want.servo_move)
                        report_mismatch("servo_move", out_data.servo_move, want.servo_move);
                    if (out_data.servo_angle !== want.servo_angle)
                        report_mismatch("servo_angle", out_data.servo_angle, want.servo_angle);
                    if (out_data.servo_out_of_range !== want.servo_out_of_range)
                        report_mismatch("servo_out_of_range", out_data.servo_out_of_range,
                                        want.servo_out_of_range);
                end
                results_taken++;
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== dv/armed_command_frame_interlock_tb.sv =====
// stimulus and verdict for the armed command frame interlock
`timescale 1ns / 100ps
module armed_command_frame_interlock_tb;
    import acfi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 8'hFF;
    localparam int PHASES         = 8;
    localparam int FRAMES_PER_SET = 235;
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_LIMIT    = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    frame_t               in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    result_t              out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ANGLE_W-1:0]   cfg_data  = '0;

    int mismatches;
    int outstanding;
    int frames_seen;
    int bad_sum_seen;
    int refused_seen;
    int moves_seen;
    int out_of_range_seen;

    bit                 idle_en    = 1'b1;
    int                 cfg_writes = 0;
    logic [ANGLE_W-1:0] cur_lo     = SERVO_MIN_RESET;
    logic [ANGLE_W-1:0] cur_hi     = SERVO_MAX_RESET;
    frame_t             last_sent  = '0;

    armed_command_frame_interlock dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    armed_command_frame_interlock_checker interlock_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_data           (in_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_data          (out_data),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .frames_seen       (frames_seen),
        .bad_sum_seen      (bad_sum_seen),
        .refused_seen      (refused_seen),
        .moves_seen        (moves_seen),
        .out_of_range_seen (out_of_range_seen)
    );

    always #10 clk = ~clk;

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, with two long hold-offs so the block backs up
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = idle_en ? $urandom_range(0, 6) : 0;
            if (taken == 150 || taken == 1000) gap = LONG_HOLD;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken++;
        end
    end

    function automatic frame_t make_frame(input logic [WORD_W-1:0] d, a, s, g, n, p, ang,
                                          input bit good);
        frame_t f;
        f.data_cmd        = d;
        f.arm_cmd         = a;
        f.solenoid_cmd    = s;
        f.ignition_cmd    = g;
        f.siren_cmd       = n;
        f.spare_word      = p;
        f.servo_angle_cmd = ang;
        f.frame_checksum  = d + a + s + g + n + p + ang;
        if (!good) f.frame_checksum = f.frame_checksum ^ (32'd1 << $urandom_range(0, 31));
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] pick_cmd();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: return CMD_ON;
            6, 7, 8, 9:       return '0;
            10, 11:           return 32'd2;
            12:               return 32'hFFFF_FFFF;
            default:          return $urandom();
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_angle();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 180);
            6:                return {24'd0, cur_lo} - 32'd1 + $urandom_range(0, 2);
            7:                return {24'd0, cur_hi} - 32'd1 + $urandom_range(0, 2);
            8:                return -$urandom_range(1, 300);
            default:          return $urandom();
        endcase
    endfunction

    // mostly well-formed frames; about a third of the words repeat the last request
    function automatic frame_t random_frame();
        logic [WORD_W-1:0] w[7];
        w[0] = ($urandom_range(0, 2) == 0) ? last_sent.data_cmd        : pick_cmd();
        w[1] = ($urandom_range(0, 2) == 0) ? last_sent.arm_cmd         : pick_cmd();
        w[2] = ($urandom_range(0, 2) == 0) ? last_sent.solenoid_cmd    : pick_cmd();
        w[3] = ($urandom_range(0, 2) == 0) ? last_sent.ignition_cmd    : pick_cmd();
        w[4] = ($urandom_range(0, 2) == 0) ? last_sent.siren_cmd       : pick_cmd();
        w[5] = ($urandom_range(0, 1) == 0) ? $urandom()                : '0;
        w[6] = ($urandom_range(0, 2) == 0) ? last_sent.servo_angle_cmd : pick_angle();
        return make_frame(w[0], w[1], w[2], w[3], w[4], w[5], w[6],
                          $urandom_range(0, 9) != 0);
    endfunction

    task automatic send_frame(input frame_t f);
        int gap;
        gap = idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        last_sent = f;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_words(input logic [WORD_W-1:0] d, a, s, g, n, p, ang,
                              input bit good);
        send_frame(make_frame(d, a, s, g, n, p, ang, good));
    endtask

    // both limits plus one write to an index the block ignores
    task automatic program_limits(input logic [ANGLE_W-1:0] lo, hi);
        logic [CFG_IDX_W-1:0] idx[3];
        logic [ANGLE_W-1:0]   val[3];
        idx[0] = REG_SERVO_MIN;
        idx[1] = REG_SERVO_MAX;
        idx[2] = $urandom_range(0, 1) ? REG_UNUSED : REG_TOP;
        val[0] = lo;
        val[1] = hi;
        val[2] = $urandom();
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        logic [ANGLE_W-1:0] lo_set[PHASES];
        logic [ANGLE_W-1:0] hi_set[PHASES];
        // a real falling edge so the asynchronous resets fire at time zero
        rst_n <= 1'b0;
        lo_set = '{8'd5,  8'd0,   8'd0, 8'd180, 8'd120, 8'd3,  8'd90,  8'd0};
        hi_set = '{8'd85, 8'd180, 8'd0, 8'd180, 8'd40,  8'd75, 8'd127, 8'd0};
        lo_set[PHASES-1] = $urandom_range(0, 180);
        hi_set[PHASES-1] = $urandom_range(lo_set[PHASES-1], 180);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_limits(lo_set[0], hi_set[0]);

        // directed frames, limits 5..85
        send_words(0, 0, 0, 0, 0, 0, 0, 1'b0);                  // bad checksum
        send_words(0, 0, 1, 0, 0, 0, 0, 1'b1);                  // solenoid while disarmed
        send_words(1, 0, 0, 1, 0, 0, 0, 1'b1);                  // data kept, ignition refused
        send_words(1, 1, 0, 0, 0, 0, 45, 1'b1);                 // arm and move
        send_words(1, 1, 1, 1, 1, 0, 45, 1'b1);                 // all on
        send_words(1, 1, 1, 1, 1, 0, 45, 1'b1);                 // nothing changed
        send_words(1, 1, 1, 1, 1, 0, 200, 1'b1);                // angle too high
        send_words(1, 1, 1, 1, 1, 0, 200, 1'b1);                // flagged again
        send_words(1, 1, 1, 1, 1, 0, 5, 1'b1);                  // at the low limit
        send_words(1, 1, 1, 1, 1, 0, 85, 1'b1);                 // at the high limit
        send_words(1, 1, 1, 1, 1, 0, 4, 1'b1);
        send_words(1, 1, 1, 1, 1, 0, 86, 1'b1);
        send_words(1, 1, 1, 1, 1, 0, 32'hFFFF_FFFF, 1'b1);      // negative angle
        send_words(1, 1, 1, 1, 1, 0, 32'h8000_0000, 1'b1);
        send_words(1, 1, 1, 1, 1, 0, 32'h7FFF_FFFF, 1'b1);
        send_words(1, 1, 1, 1, 1, 0, 32'h0000_0105, 1'b1);      // low byte in range
        // checksum that matches the angle word instead of the sum
        send_frame('{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd5, 32'd5});
        send_words(1, 2, 1, 1, 1, 0, 60, 1'b1);                 // disarm clears outputs
        send_words(1, 2, 1, 1, 1, 0, 60, 1'b1);                 // same on-words do not act
        send_words(1, 2, 1, 0, 1, 0, 60, 1'b1);
        send_words(1, 2, 1, 1, 0, 0, 60, 1'b1);                 // refused, siren untouched
        send_words(1, 1, 1, 0, 1, 0, 60, 1'b1);                 // rearm, siren stays off
        send_words(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        send_words(0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_words(1, 1, 32'd2, 1, 0, 32'h5555_AAAA, 30, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                program_limits(lo_set[ph], hi_set[ph]);
            end
            idle_en = (ph % 3 != 2);
            for (int n = 0; n < FRAMES_PER_SET; n++) send_frame(random_frame());
        end
        idle_en = 1'b1;
        drain();

        $display("covered %0d frames: %0d bad checksum, %0d refused while disarmed",
                 frames_seen, bad_sum_seen, refused_seen);
        $display("servo moved %0d times, %0d angles out of limits, %0d register writes",
                 moves_seen, out_of_range_seen, cfg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/acfi_pkg.sv
sv/acfi_in_stage.sv
sv/acfi_ctrl.sv
sv/armed_command_frame_interlock.sv
sv/acfi_checker.sv
dv/armed_command_frame_interlock_checker.sv
dv/armed_command_frame_interlock_tb.sv
